### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the matrix multiplier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

### sv/mmul_pkg.sv
// Shared constants, types and helper functions of the matrix multiplier.
`default_nettype none

package mmul_pkg;

   // Sizing
   localparam int MAX_DIM    = 8;
   localparam int ELEM_WIDTH = 16;
   localparam int CFG_W      = 4;
   localparam int PROD_W     = 35;
   localparam int OUT_IDX_W  = 3;
   localparam int DIM_W      = $clog2(MAX_DIM + 1);
   localparam int IDX_W      = $clog2(MAX_DIM);
   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int MUL_W      = 2 * ELEM_WIDTH;

   // Stream word widths, padded to whole bytes
   localparam int REQ_DATA_W  = ((ELEM_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELD_W = PROD_W + 2 * OUT_IDX_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // Register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam logic [CFG_W-1:0] CFG_RESET_VALUE = 4'd8;
   localparam logic [CSR_ADDR_W-3:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_ADDR_W-3:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_ADDR_W-3:0] REG_COLS_B    = 2'd2;

   // Control word from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic clear;   // zero the accumulator for a new product element
      logic valid;   // operands on the RAM outputs are live this cycle
   } mac_ctl_type;

   // Clamp a dimension register into 1..MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/mmul_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mmul_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### sv/mmul_mac.sv
// Shared multiply-accumulate unit: registered multiply, then accumulate.
`default_nettype none

module mmul_mac (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mmul_pkg::mac_ctl_type               ctl,
   input  wire logic [mmul_pkg::ELEM_WIDTH-1:0]     a_data,
   input  wire logic [mmul_pkg::ELEM_WIDTH-1:0]     b_data,
   output logic                                     busy,
   output logic      [mmul_pkg::PROD_W-1:0]         acc
);
   import mmul_pkg::*;

   logic                     mul_valid_ff;
   logic signed [MUL_W-1:0]  prod_ff;
   logic [PROD_W-1:0]        acc_ff;

   // Multiply stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= ctl.valid;
      end
   end

   // Multiply, then add the sign-extended product; wrap to the result width
   always_ff @(posedge clock) begin
      prod_ff <= $signed(a_data) * $signed(b_data);
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (mul_valid_ff) begin
         acc_ff <= acc_ff + PROD_W'(prod_ff);
      end
   end

   assign busy = mul_valid_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

### sv/matrix_multiply.sv
// Matrix multiplier: load takes one element per cycle while idle, with no result.
// After the word that fills B, each product element is accumulated over the inner
// dimension on the shared multiply-accumulate unit, then drained and emitted as one word.
// req_tready is low for the whole run of rows_a * cols_b product elements.
// Reset sets the dimension registers to 8 and the load counters to zero;
// the element RAMs are not cleared and hold nothing defined until loaded.
`default_nettype none

module matrix_multiply (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [mmul_pkg::REQ_DATA_W-1:0]     req_tdata,  // [15:0] element_value
   input  wire logic                                req_tuser,  // [0] matrix_sel
   // Result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [mmul_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [34:0] product_value,
                                                                // [37:35] out_row,
                                                                // [40:38] out_col
   output logic                                     rsp_tlast,  // is_last
   // Register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [mmul_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [mmul_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [mmul_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);
   import mmul_pkg::*;

`include "assert_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_ISSUE = 3'b010,
      S_EMIT  = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [CFG_W-1:0]    rows_ff, inner_ff, cols_ff;
   logic [CNT_W-1:0]    a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   logic [IDX_W-1:0]    i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [ADDR_W-1:0]   a_base_ff, a_base_in, a_ptr_ff, a_ptr_in, b_ptr_ff, b_ptr_in;
   logic                rd_valid_ff;
   logic                rsp_valid_ff;
   logic [PROD_W-1:0]   rsp_prod_ff;
   logic [OUT_IDX_W-1:0] rsp_row_ff, rsp_col_ff;
   logic                rsp_last_ff;

   logic [DIM_W-1:0]    nr, nk, nc;
   logic [CNT_W-1:0]    a_total, b_total;
   logic [CNT_W-1:0]    a_idx, b_idx, a_next, b_next;
   logic                req_take, a_wr_en, b_wr_en, b_full;
   logic                out_free, pipe_empty, last_i, last_j, last_k, emit;
   logic                csr_wr;
   logic [ELEM_WIDTH-1:0] elem;
   logic [ELEM_WIDTH-1:0] a_rd_data, b_rd_data;
   logic [PROD_W-1:0]   mac_acc;
   logic                mac_busy;
   mac_ctl_type         mac_ctl;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= CFG_RESET_VALUE;
         inner_ff <= CFG_RESET_VALUE;
         cols_ff  <= CFG_RESET_VALUE;
      end else if (csr_wr) begin
         case (csr_paddr[CSR_ADDR_W-1:2])
            REG_ROWS_A:    rows_ff  <= csr_pwdata[CFG_W-1:0];
            REG_INNER_DIM: inner_ff <= csr_pwdata[CFG_W-1:0];
            REG_COLS_B:    cols_ff  <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_ADDR_W-1:2])
         REG_ROWS_A:    csr_prdata = CSR_DATA_W'(rows_ff);
         REG_INNER_DIM: csr_prdata = CSR_DATA_W'(inner_ff);
         REG_COLS_B:    csr_prdata = CSR_DATA_W'(cols_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Effective sizes
   assign nr      = eff_dim(rows_ff);
   assign nk      = eff_dim(inner_ff);
   assign nc      = eff_dim(cols_ff);
   assign a_total = CNT_W'(nr) * CNT_W'(nk);
   assign b_total = CNT_W'(nk) * CNT_W'(nc);

   // Load path: restart a counter left beyond its matrix, write, advance
   assign elem       = req_tdata[ELEM_WIDTH-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid & req_tready;
   assign a_wr_en    = req_take & ~req_tuser;
   assign b_wr_en    = req_take & req_tuser;
   assign a_idx      = (a_cnt_ff >= a_total) ? '0 : a_cnt_ff;
   assign b_idx      = (b_cnt_ff >= b_total) ? '0 : b_cnt_ff;
   assign a_next     = a_idx + CNT_W'(1);
   assign b_next     = b_idx + CNT_W'(1);
   assign b_full     = (b_next >= b_total);

   always_comb begin
      a_cnt_in = a_cnt_ff;
      b_cnt_in = b_cnt_ff;
      if (a_wr_en) begin
         a_cnt_in = (a_next >= a_total) ? '0 : a_next;
      end
      if (b_wr_en) begin
         b_cnt_in = b_full ? '0 : b_next;
      end
   end

   // Element stores
   mmul_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_idx[ADDR_W-1:0]),
      .wr_data (elem),
      .rd_addr (a_ptr_ff),
      .rd_data (a_rd_data)
   );

   mmul_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_idx[ADDR_W-1:0]),
      .wr_data (elem),
      .rd_addr (b_ptr_ff),
      .rd_data (b_rd_data)
   );

   // Sequencer: walk k for each (i, j), then drain and emit
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign pipe_empty = ~rd_valid_ff & ~mac_busy;
   assign last_i     = (DIM_W'(i_ff) == nr - DIM_W'(1));
   assign last_j     = (DIM_W'(j_ff) == nc - DIM_W'(1));
   assign last_k     = (DIM_W'(k_ff) == nk - DIM_W'(1));
   assign emit       = (state_ff == S_EMIT) & pipe_empty & out_free;

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      a_base_in = a_base_ff;
      a_ptr_in  = a_ptr_ff;
      b_ptr_in  = b_ptr_ff;
      mac_ctl.clear = 1'b0;
      mac_ctl.valid = rd_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (b_wr_en && b_full) begin
               state_in      = S_ISSUE;
               i_in          = '0;
               j_in          = '0;
               k_in          = '0;
               a_base_in     = '0;
               a_ptr_in      = '0;
               b_ptr_in      = '0;
               mac_ctl.clear = 1'b1;
            end
         end
         S_ISSUE: begin
            a_ptr_in = a_ptr_ff + ADDR_W'(1);
            b_ptr_in = b_ptr_ff + ADDR_W'(nc);
            k_in     = k_ff + IDX_W'(1);
            if (last_k) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit) begin
               if (last_i && last_j) begin
                  state_in = S_IDLE;
               end else begin
                  state_in      = S_ISSUE;
                  k_in          = '0;
                  mac_ctl.clear = 1'b1;
                  if (last_j) begin
                     j_in      = '0;
                     i_in      = i_ff + IDX_W'(1);
                     a_base_in = a_base_ff + ADDR_W'(nk);
                     a_ptr_in  = a_base_ff + ADDR_W'(nk);
                     b_ptr_in  = '0;
                  end else begin
                     j_in     = j_ff + IDX_W'(1);
                     a_ptr_in = a_base_ff;
                     b_ptr_in = ADDR_W'(j_ff) + ADDR_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         a_cnt_ff    <= '0;
         b_cnt_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         a_cnt_ff    <= a_cnt_in;
         b_cnt_ff    <= b_cnt_in;
         rd_valid_ff <= (state_ff == S_ISSUE);
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      a_base_ff <= a_base_in;
      a_ptr_ff  <= a_ptr_in;
      b_ptr_ff  <= b_ptr_in;
   end

   // Shared multiply-accumulate
   mmul_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .a_data (a_rd_data),
      .b_data (b_rd_data),
      .busy   (mac_busy),
      .acc    (mac_acc)
   );

   // Output register: load a finished word, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_prod_ff <= mac_acc;
         rsp_row_ff  <= OUT_IDX_W'(i_ff);
         rsp_col_ff  <= OUT_IDX_W'(j_ff);
         rsp_last_ff <= last_i & last_j;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_col_ff, rsp_row_ff, rsp_prod_ff});
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `ASSERT_IMPLIES(a_ready_pipe_empty, clock, reset, req_tready, pipe_empty,
      "input accepted while products are still in flight")
   `ASSERT_IMPLIES(a_clear_pipe_empty, clock, reset, mac_ctl.clear, pipe_empty,
      "accumulator cleared with products in flight")
   `ASSERT_IMPLIES(a_last_idle, clock, reset, emit && last_i && last_j,
      state_in == S_IDLE, "sequencer still busy after the last word")
   `ASSERT_HOLDS(a_read_range, clock, reset,
      (state_ff != S_ISSUE) ||
      ((CNT_W'(a_ptr_ff) < a_total) && (CNT_W'(b_ptr_ff) < b_total)),
      "store read beyond the loaded matrix")

endmodule

`default_nettype wire

### tb/sv/matrix_multiply_tb.sv
// Self-checking testbench for the matrix multiplier: directed table, then random phases.
module matrix_multiply_tb;
   import mmul_pkg::*;

   localparam logic SEL_A = 1'b0;
   localparam logic SEL_B = 1'b1;
   localparam int RANDOM_ITEMS = 436;
   localparam int IDLE_GUARD   = 24;
   localparam int HOLD_CYCLES  = 1500;
   localparam int REPORT_LIMIT = 10;
   localparam int DIRECTED_ROWS = 37;

   typedef logic [CSR_ADDR_W-3:0] reg_idx_type;

   typedef struct packed {
      logic [PROD_W-1:0]    value;
      logic [OUT_IDX_W-1:0] row;
      logic [OUT_IDX_W-1:0] col;
      logic                 last;
   } product_type;

   typedef enum logic {ROW_CFG, ROW_ELEM} row_kind_type;

   typedef struct {
      row_kind_type                 kind;
      reg_idx_type                  reg_idx;
      logic [CFG_W-1:0]             cfg_value;
      logic                         sel;
      logic signed [ELEM_WIDTH-1:0] value;
      logic                         typed;
      product_type                  want;
   } step_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_DATA_W-1:0]      req_tdata;   // [15:0] element_value
   logic                       req_tuser;   // [0] matrix_sel
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_DATA_W-1:0]      rsp_tdata;   // [34:0] product_value, [37:35] out_row,
                                            // [40:38] out_col
   logic                       rsp_tlast;   // is_last
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_ADDR_W-1:0]      csr_paddr;
   logic [CSR_DATA_W-1:0]      csr_pwdata;
   logic [CSR_DATA_W-1:0]      csr_prdata;
   logic                       csr_pready;

   // Predictor state: dimension registers, element stores and load positions
   logic [CFG_W-1:0]             rows_cfg;
   logic [CFG_W-1:0]             inner_cfg;
   logic [CFG_W-1:0]             cols_cfg;
   logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
   logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];
   bit                           a_written [DEPTH];
   int                           a_fill;
   int                           b_fill;

   product_type pending_products[$];
   product_type fresh_products[$];
   step_type    directed_steps [DIRECTED_ROWS];

   int fail_count;
   int sent_random;
   bit quiet;
   bit stall_request;
   int hold_left;

   matrix_multiply DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Map a register value onto the size it acts as: zero is one, above the maximum is the maximum
   function automatic int clamp_dim(input logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   // Load one element; on the word that fills B, build the whole product
   function automatic void apply_element(input logic sel,
                                         input logic signed [ELEM_WIDTH-1:0] val);
      int          nr, nk, nc, total;
      longint      acc;
      product_type p;
      fresh_products.delete();
      nr = clamp_dim(rows_cfg);
      nk = clamp_dim(inner_cfg);
      nc = clamp_dim(cols_cfg);
      if (sel == SEL_A) begin
         total = nr * nk;
         if (a_fill >= total) a_fill = 0;
         a_mem[a_fill] = val;
         a_written[a_fill] = 1'b1;
         a_fill++;
         if (a_fill >= total) a_fill = 0;
         return;
      end
      total = nk * nc;
      if (b_fill >= total) b_fill = 0;
      b_mem[b_fill] = val;
      b_fill++;
      if (b_fill < total) return;
      b_fill = 0;
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < nk; k++) begin
               acc += longint'(a_mem[i * nk + k]) * longint'(b_mem[k * nc + j]);
            end
            p.value = acc[PROD_W-1:0];
            p.row   = OUT_IDX_W'(i);
            p.col   = OUT_IDX_W'(j);
            p.last  = (i == nr - 1) && (j == nc - 1);
            fresh_products.push_back(p);
         end
      end
   endfunction

   // True when the next B word would fill B while part of A was never loaded
   function automatic bit completion_unsafe();
      int nr, nk, nc, next;
      nr = clamp_dim(rows_cfg);
      nk = clamp_dim(inner_cfg);
      nc = clamp_dim(cols_cfg);
      next = (b_fill >= nk * nc) ? 0 : b_fill;
      if (next + 1 < nk * nc) return 1'b0;
      for (int n = 0; n < nr * nk; n++) begin
         if (!a_written[n]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic signed [ELEM_WIDTH-1:0] rand_element();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return 16'sh8000;
      if (pick < 16) return 16'sh7FFF;
      if (pick < 20) return '0;
      return ELEM_WIDTH'($urandom());
   endfunction

   // Mostly small sizes, now and then a larger one, zero or an out-of-range value
   function automatic logic [CFG_W-1:0] pick_dim();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return CFG_W'($urandom_range(1, 3));
      if (pick < 85) return CFG_W'($urandom_range(4, MAX_DIM));
      if (pick < 92) return '0;
      return CFG_W'($urandom_range(MAX_DIM + 1, 15));
   endfunction

   function automatic step_type cfg_row(input reg_idx_type idx, input logic [CFG_W-1:0] v);
      return '{ROW_CFG, idx, v, SEL_A, '0, 1'b0, '0};
   endfunction

   function automatic step_type elem_row(input logic sel,
                                         input logic signed [ELEM_WIDTH-1:0] v);
      return '{ROW_ELEM, REG_ROWS_A, '0, sel, v, 1'b0, '0};
   endfunction

   function automatic step_type typed_row(input logic signed [ELEM_WIDTH-1:0] v,
                                          input product_type w);
      return '{ROW_ELEM, REG_ROWS_A, '0, SEL_B, v, 1'b1, w};
   endfunction

   // Drop valid, let every expected word drain, then give the block time to settle
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_products.size() != 0) @(posedge clock);
      repeat (IDLE_GUARD) @(posedge clock);
   endtask

   task automatic write_register(input reg_idx_type idx, input logic [CFG_W-1:0] v);
      wait_idle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {(CSR_DATA_W - CFG_W)'($urandom()), v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_ROWS_A:    rows_cfg  = v;
         REG_INNER_DIM: inner_cfg = v;
         REG_COLS_B:    cols_cfg  = v;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offer one element word, wait for acceptance and queue what it produces
   task automatic push_element(input logic sel, input logic signed [ELEM_WIDTH-1:0] val,
                               input logic typed, input product_type want);
      while (!quiet && $urandom_range(0, 99) < 12) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= val;
      req_tuser  <= sel;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_element(sel, val);
      if (typed) begin
         pending_products.push_back(want);
      end else begin
         foreach (fresh_products[n]) pending_products.push_back(fresh_products[n]);
      end
   endtask

   // Never fill B before every A entry it needs was loaded; stop at the item budget
   task automatic send_random_word(input logic sel);
      if (sent_random >= RANDOM_ITEMS) return;
      if (sel == SEL_B && completion_unsafe()) sel = SEL_A;
      push_element(sel, rand_element(), 1'b0, '0);
      sent_random++;
      quiet = (sent_random >= 150) && (sent_random < 260);
   endtask

   task automatic check_product();
      product_type got;
      product_type want;
      got = '{rsp_tdata[PROD_W-1:0], rsp_tdata[PROD_W+OUT_IDX_W-1:PROD_W],
              rsp_tdata[PROD_W+2*OUT_IDX_W-1:PROD_W+OUT_IDX_W], rsp_tlast};
      if (pending_products.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("unexpected word: value %0d row %0d col %0d last %0b",
                     $signed(got.value), got.row, got.col, got.last);
         return;
      end
      want = pending_products.pop_front();
      if (got.value != want.value || got.row != want.row || got.col != want.col ||
          got.last != want.last) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("word mismatch: expected value %0d row %0d col %0d last %0b",
                     $signed(want.value), want.row, want.col, want.last);
            $display("               got value %0d row %0d col %0d last %0b",
                     $signed(got.value), got.row, got.col, got.last);
         end
      end
   endtask

   // Result side: random stalls, one long hold-off on request, check every word
   initial begin
      logic ready_next;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            ready_next = 1'b0;
            hold_left--;
         end else if (stall_request) begin
            stall_request = 1'b0;
            hold_left = HOLD_CYCLES;
            ready_next = 1'b0;
         end else begin
            ready_next = quiet || ($urandom_range(0, 99) >= 12);
         end
         rsp_tready <= ready_next;
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_product();
      end
   end

   // Stimulus
   initial begin
      reg_idx_type reg_list [3];
      int          nr, nk, nc, reps;
      int          phase;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      rows_cfg = CFG_RESET_VALUE;
      inner_cfg = CFG_RESET_VALUE;
      cols_cfg = CFG_RESET_VALUE;
      a_fill = 0;
      b_fill = 0;
      foreach (a_written[n]) a_written[n] = 1'b0;
      fail_count = 0;
      sent_random = 0;
      quiet = 1'b0;
      stall_request = 1'b0;
      hold_left = 0;
      reg_list = '{REG_ROWS_A, REG_INNER_DIM, REG_COLS_B};

      directed_steps = '{
         // 1x1x1 with the element extremes
         cfg_row(REG_ROWS_A, 4'd1), cfg_row(REG_INNER_DIM, 4'd1), cfg_row(REG_COLS_B, 4'd1),
         elem_row(SEL_A, 16'sh8000),
         typed_row(16'sh8000, '{35'h0_4000_0000, 3'd0, 3'd0, 1'b1}),
         elem_row(SEL_A, 16'sh7FFF),
         typed_row(16'sh8000, '{-35'sd1073709056, 3'd0, 3'd0, 1'b1}),
         elem_row(SEL_A, 16'sh7FFF),
         typed_row(16'sh7FFF, '{35'sd1073676289, 3'd0, 3'd0, 1'b1}),
         // zero sizes act as one
         cfg_row(REG_ROWS_A, 4'd0), cfg_row(REG_INNER_DIM, 4'd0), cfg_row(REG_COLS_B, 4'd0),
         elem_row(SEL_A, 16'sd5),
         typed_row(-16'sd7, '{-35'sd35, 3'd0, 3'd0, 1'b1}),
         // oversized row count acts as the maximum: 8x1 times 1x1
         cfg_row(REG_ROWS_A, 4'd15),
         elem_row(SEL_A, 16'sh8000), elem_row(SEL_A, 16'sh7FFF), elem_row(SEL_A, 16'sd1),
         elem_row(SEL_A, -16'sd1), elem_row(SEL_A, 16'sd0), elem_row(SEL_A, 16'sh5555),
         elem_row(SEL_A, 16'shAAAA), elem_row(SEL_A, 16'sd12345),
         elem_row(SEL_B, 16'sh8000),
         // leave the A position past the new size, then shrink A
         cfg_row(REG_ROWS_A, 4'd2), cfg_row(REG_INNER_DIM, 4'd2), cfg_row(REG_COLS_B, 4'd2),
         elem_row(SEL_A, 16'sd100), elem_row(SEL_A, -16'sd200), elem_row(SEL_A, 16'sd300),
         cfg_row(REG_ROWS_A, 4'd1),
         elem_row(SEL_A, 16'sd7), elem_row(SEL_A, -16'sd9),
         elem_row(SEL_B, 16'sd1), elem_row(SEL_B, 16'sd2), elem_row(SEL_B, 16'sd3),
         elem_row(SEL_B, 16'sd4)
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_steps[s]) begin
         if (directed_steps[s].kind == ROW_CFG)
            write_register(directed_steps[s].reg_idx, directed_steps[s].cfg_value);
         else
            push_element(directed_steps[s].sel, directed_steps[s].value,
                         directed_steps[s].typed, directed_steps[s].want);
      end

      // Random phases: mostly whole A and B loads, some loose words
      phase = 0;
      while (sent_random < RANDOM_ITEMS) begin
         foreach (reg_list[r]) begin
            if (phase == 0) write_register(reg_list[r], 4'(MAX_DIM));
            else if ($urandom_range(0, 3) != 0) write_register(reg_list[r], pick_dim());
         end
         nr = clamp_dim(rows_cfg);
         nk = clamp_dim(inner_cfg);
         nc = clamp_dim(cols_cfg);
         if (phase == 0) stall_request = 1'b1;
         if (phase == 0 || $urandom_range(0, 99) < 80) begin
            reps = (phase == 0) ? 2 : $urandom_range(1, 2);
            for (int r = 0; r < reps; r++) begin
               if (r == 0 || $urandom_range(0, 1) == 1)
                  repeat (nr * nk) send_random_word(SEL_A);
               repeat (nk * nc) send_random_word(SEL_B);
            end
         end else begin
            repeat ($urandom_range(1, 10)) send_random_word(1'($urandom_range(0, 1)));
         end
         phase++;
      end

      // Drain and let the pipeline settle
      wait_idle();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog
   initial begin
      #10000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
